FILE: hdl/dcaw_pkg.sv
// Shared types, constants and the arctangent table for the drive command arbiter.
// No dependencies; every other file imports this package.
`default_nettype none

package dcaw_pkg;

   localparam int VAL_W     = 24;
   localparam int PCT_W     = 16;
   localparam int GAIN_W    = 15;
   localparam int VMAX_W    = 23;
   localparam int TICK_W    = 8;
   localparam int CNT_W     = 16;
   localparam int SRC_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_SRC   = 3;

   // scaled speed: |value| * 25600 fits 38 bits, signed quotient 39 bits
   localparam int QUO_W     = 38;
   localparam int SVAL_W    = QUO_W + 1;
   localparam int CORDIC_W  = 44;
   localparam int ANGLE_W   = 32;
   localparam int SQRT_W    = 32;
   localparam int STEP_W    = 6;

   localparam int CORDIC_ITER = 23;
   localparam int SQRT_ITER   = 16;

   localparam logic [GAIN_W-1:0] PCT_SCALE = GAIN_W'(25600);

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_JOY  = 2'd1;
   localparam logic [1:0] MODE_MOV  = 2'd2;
   localparam logic [1:0] MODE_AUX  = 2'd3;

   localparam logic [1:0] FMT_NONE      = 2'd0;
   localparam logic [1:0] FMT_PCT_POLAR = 2'd1;
   localparam logic [1:0] FMT_SPD_POLAR = 2'd2;
   localparam logic [1:0] FMT_SPD_CART  = 2'd3;

   localparam logic [SRC_W-1:0] SRC_MOV = 2'd0;
   localparam logic [SRC_W-1:0] SRC_AUX = 2'd1;
   localparam logic [SRC_W-1:0] SRC_JOY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_LIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ANG = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_JOY_THR = 3'd4;

   typedef struct packed {
      logic [1:0]              fmt;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] d;
   } calc_req_type;

   typedef struct packed {
      logic                start;
      logic [VMAX_W-1:0]   max_lin;
      logic [VMAX_W-1:0]   max_ang;
   } calc_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } calc_sts_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] dir;
      logic signed [PCT_W-1:0] lin;
      logic signed [PCT_W-1:0] ang;
      logic [GAIN_W-1:0]       gain;
   } src_vals_type;

   // atan(2^-i) in degrees, Q.16
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANGLE_W-1:0] v;
      case (idx)
         5'd0:  v = 32'sd2949120;
         5'd1:  v = 32'sd1740967;
         5'd2:  v = 32'sd919879;
         5'd3:  v = 32'sd466945;
         5'd4:  v = 32'sd234379;
         5'd5:  v = 32'sd117304;
         5'd6:  v = 32'sd58666;
         5'd7:  v = 32'sd29335;
         5'd8:  v = 32'sd14668;
         5'd9:  v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/dcaw_if.sv
// Valid/ready channel interfaces: command request, tick response, register write.
// Depends on dcaw_pkg for field widths.
`default_nettype none

interface dcaw_req_if import dcaw_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              mode;
   logic [1:0]              format;
   logic signed [VAL_W-1:0] value_a;
   logic signed [VAL_W-1:0] value_b;
   logic signed [VAL_W-1:0] value_c;
   logic signed [VAL_W-1:0] value_d;
   modport source (output valid, mode, format, value_a, value_b, value_c, value_d,
                   input ready);
   modport sink   (input valid, mode, format, value_a, value_b, value_c, value_d,
                   output ready);
endinterface

interface dcaw_rsp_if import dcaw_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] direction_out;
   logic signed [PCT_W-1:0] linear_out;
   logic signed [PCT_W-1:0] angular_out;
   logic [GAIN_W-1:0]       gain_out;
   logic [SRC_W-1:0]        selected_source;
   logic [CNT_W-1:0]        movement_timeouts;
   logic [CNT_W-1:0]        joystick_timeouts;
   logic [CNT_W-1:0]        auxiliary_timeouts;
   modport source (output valid, direction_out, linear_out, angular_out, gain_out,
                   selected_source, movement_timeouts, joystick_timeouts,
                   auxiliary_timeouts, input ready);
   modport sink   (input valid, direction_out, linear_out, angular_out, gain_out,
                   selected_source, movement_timeouts, joystick_timeouts,
                   auxiliary_timeouts, output ready);
endinterface

interface dcaw_csr_if import dcaw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VMAX_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dcaw_calc.sv
// Command format conversion: restoring divider, bit-serial square root and CORDIC
// atan2, all stepped by one sequencer. Depends on dcaw_pkg.
`default_nettype none

module dcaw_calc import dcaw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire calc_ctl_type ctl,
   input  wire calc_req_type req,
   output calc_sts_type      sts,
   output src_vals_type      res
);

   localparam logic [3:0] C_IDLE     = 4'd0;
   localparam logic [3:0] C_SC_LOAD  = 4'd1;
   localparam logic [3:0] C_SC_DIV   = 4'd2;
   localparam logic [3:0] C_SC_STORE = 4'd3;
   localparam logic [3:0] C_SQ_X     = 4'd4;
   localparam logic [3:0] C_SQ_Y     = 4'd5;
   localparam logic [3:0] C_SQ_RUN   = 4'd6;
   localparam logic [3:0] C_CD_INIT  = 4'd7;
   localparam logic [3:0] C_CD_NORM  = 4'd8;
   localparam logic [3:0] C_CD_RUN   = 4'd9;
   localparam logic [3:0] C_CD_ROUND = 4'd10;
   localparam logic [3:0] C_DONE     = 4'd11;

   localparam logic [1:0] OP_A = 2'd0;
   localparam logic [1:0] OP_B = 2'd1;
   localparam logic [1:0] OP_C = 2'd2;

   localparam logic signed [SVAL_W-1:0]   PCT_POS  = SVAL_W'(25600);
   localparam logic signed [SVAL_W-1:0]   PCT_NEG  = -SVAL_W'(25600);
   localparam logic signed [CORDIC_W-1:0] NORM_POS = CORDIC_W'(64'sd1 <<< 40);
   localparam logic signed [CORDIC_W-1:0] NORM_NEG = -CORDIC_W'(64'sd1 <<< 40);
   localparam logic signed [ANGLE_W-1:0]  Z_HALF   = 32'sd11796480;
   localparam logic signed [ANGLE_W-1:0]  WRAP_LIM = 32'sd46080;
   localparam logic signed [ANGLE_W-1:0]  WRAP_SPAN = 32'sd92160;
   localparam logic signed [ANGLE_W-1:0]  ROUND_HALF = 32'sd128;
   localparam logic [SQRT_W-1:0]          SQ_BIT_TOP = SQRT_W'(1) << 30;

   function automatic logic signed [PCT_W-1:0] clamp_pct(input logic signed [SVAL_W-1:0] v);
      logic signed [PCT_W-1:0] r;
      if (v > PCT_POS) r = PCT_W'(PCT_POS);
      else if (v < PCT_NEG) r = PCT_W'(PCT_NEG);
      else r = v[PCT_W-1:0];
      return r;
   endfunction

   logic [3:0]                 state_ff, state_in;
   calc_req_type               req_ff, req_in;
   logic [VMAX_W-1:0]          mlin_ff, mlin_in, mang_ff, mang_in;
   logic [1:0]                 op_ff, op_in;
   logic                       neg_ff, neg_in;
   logic [QUO_W-1:0]           num_ff, num_in;
   logic [VMAX_W-1:0]          rem_ff, rem_in, den_ff, den_in;
   logic [STEP_W-1:0]          cnt_ff, cnt_in;
   logic signed [SVAL_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [SQRT_W-1:0]          sqn_ff, sqn_in, sqr_ff, sqr_in, sqb_ff, sqb_in;
   logic signed [CORDIC_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   src_vals_type               res_ff, res_in;

   logic signed [VAL_W-1:0]    op_val;
   logic [VAL_W-1:0]           op_mag;
   logic [SVAL_W-1:0]          prod;
   logic [VMAX_W:0]            rem_sh;
   logic signed [SVAL_W-1:0]   quo;
   logic signed [PCT_W-1:0]    x16, y16;
   logic signed [SQRT_W-1:0]   sq_prod;
   logic [SQRT_W-1:0]          sq_try;
   logic signed [CORDIC_W-1:0] dx, dy, vx0, vy0;
   logic signed [ANGLE_W-1:0]  rz;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      mlin_in  = mlin_ff;
      mang_in  = mang_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      sqn_in   = sqn_ff;
      sqr_in   = sqr_ff;
      sqb_in   = sqb_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      z_in     = z_ff;
      res_in   = res_ff;

      case (op_ff)
         OP_A:    op_val = req_ff.a;
         OP_B:    op_val = req_ff.b;
         default: op_val = req_ff.c;
      endcase
      op_mag  = op_val[VAL_W-1] ? VAL_W'(-op_val) : VAL_W'(op_val);
      prod    = SVAL_W'({{(SVAL_W-VAL_W){1'b0}}, op_mag} *
                        {{(SVAL_W-GAIN_W){1'b0}}, PCT_SCALE});
      rem_sh  = {rem_ff, num_ff[QUO_W-1]};
      quo     = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
      x16     = x_ff[PCT_W-1:0];
      y16     = y_ff[PCT_W-1:0];
      sq_prod = (state_ff == C_SQ_X) ? SQRT_W'(x16) * SQRT_W'(x16)
                                     : SQRT_W'(y16) * SQRT_W'(y16);
      sq_try  = sqr_ff + sqb_ff;
      dx      = vy_ff >>> cnt_ff[4:0];
      dy      = vx_ff >>> cnt_ff[4:0];
      vx0     = CORDIC_W'(y_ff);
      vy0     = CORDIC_W'(x_ff);
      rz      = (z_ff + ROUND_HALF) >>> 8;
      if (rz > WRAP_LIM) rz = rz - WRAP_SPAN;
      else if (rz <= -WRAP_LIM) rz = rz + WRAP_SPAN;

      case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               req_in  = req;
               mlin_in = (ctl.max_lin == '0) ? VMAX_W'(1) : ctl.max_lin;
               mang_in = (ctl.max_ang == '0) ? VMAX_W'(1) : ctl.max_ang;
               op_in   = (req.fmt == FMT_SPD_CART) ? OP_A : OP_B;
               if (req.fmt == FMT_PCT_POLAR) begin
                  res_in.dir = req.a;
                  res_in.lin = clamp_pct(SVAL_W'(req.b));
                  res_in.ang = clamp_pct(SVAL_W'(req.c));
                  if (req.d < 0) res_in.gain = '0;
                  else if (req.d > VAL_W'(PCT_SCALE)) res_in.gain = PCT_SCALE;
                  else res_in.gain = req.d[GAIN_W-1:0];
                  state_in = C_DONE;
               end else begin
                  state_in = C_SC_LOAD;
               end
            end
         end
         C_SC_LOAD: begin
            neg_in   = op_val[VAL_W-1];
            num_in   = prod[QUO_W-1:0];
            den_in   = (op_ff == OP_C) ? mang_ff : mlin_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = C_SC_DIV;
         end
         C_SC_DIV: begin
            // one quotient bit per cycle
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = VMAX_W'(rem_sh - {1'b0, den_ff});
               num_in = {num_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[VMAX_W-1:0];
               num_in = {num_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(QUO_W - 1)) state_in = C_SC_STORE;
         end
         C_SC_STORE: begin
            case (op_ff)
               OP_A:    x_in = quo;
               OP_B:    y_in = quo;
               default: ;
            endcase
            if (op_ff == OP_C) begin
               res_in.ang  = clamp_pct(quo);
               res_in.gain = PCT_SCALE;
               if (req_ff.fmt == FMT_SPD_POLAR) begin
                  res_in.dir = req_ff.a;
                  res_in.lin = clamp_pct(y_ff);
                  state_in   = C_DONE;
               end else begin
                  state_in   = C_SQ_X;
               end
            end else begin
               op_in    = op_ff + 2'd1;
               state_in = C_SC_LOAD;
            end
         end
         C_SQ_X: begin
            if (x_ff > PCT_POS || x_ff < PCT_NEG || y_ff > PCT_POS || y_ff < PCT_NEG) begin
               res_in.lin = PCT_W'(PCT_POS);
               state_in   = C_CD_INIT;
            end else begin
               sqn_in   = sq_prod;
               state_in = C_SQ_Y;
            end
         end
         C_SQ_Y: begin
            sqn_in   = sqn_ff + sq_prod;
            sqr_in   = '0;
            sqb_in   = SQ_BIT_TOP;
            cnt_in   = '0;
            state_in = C_SQ_RUN;
         end
         C_SQ_RUN: begin
            if (sqn_ff >= sq_try) begin
               sqn_in = sqn_ff - sq_try;
               sqr_in = (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_in = sqr_ff >> 1;
            end
            sqb_in = sqb_ff >> 2;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(SQRT_ITER - 1)) begin
               state_in = C_CD_INIT;
            end
         end
         C_CD_INIT: begin
            if (state_ff == C_CD_INIT && sqb_ff == '0 && x_ff <= PCT_POS && x_ff >= PCT_NEG &&
                y_ff <= PCT_POS && y_ff >= PCT_NEG) begin
               res_in.lin = (sqr_ff > SQRT_W'(25600)) ? PCT_W'(PCT_POS) : sqr_ff[PCT_W-1:0];
            end
            if (x_ff == '0 && y_ff == '0) begin
               res_in.dir = '0;
               state_in   = C_DONE;
            end else begin
               if (y_ff < 0) begin
                  vx_in = -vx0;
                  vy_in = -vy0;
                  z_in  = Z_HALF;
               end else begin
                  vx_in = vx0;
                  vy_in = vy0;
                  z_in  = '0;
               end
               state_in = C_CD_NORM;
            end
         end
         C_CD_NORM: begin
            // shift up until the larger magnitude reaches 2^40
            if (vx_ff < NORM_POS && vx_ff > NORM_NEG && vy_ff < NORM_POS && vy_ff > NORM_NEG)
            begin
               vx_in = vx_ff <<< 1;
               vy_in = vy_ff <<< 1;
            end else begin
               cnt_in   = '0;
               state_in = C_CD_RUN;
            end
         end
         C_CD_RUN: begin
            if (vy_ff >= 0) begin
               vx_in = vx_ff + dx;
               vy_in = vy_ff - dy;
               z_in  = z_ff + atan_entry(cnt_ff[4:0]);
            end else begin
               vx_in = vx_ff - dx;
               vy_in = vy_ff + dy;
               z_in  = z_ff - atan_entry(cnt_ff[4:0]);
            end
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(CORDIC_ITER - 1)) state_in = C_CD_ROUND;
         end
         C_CD_ROUND: begin
            res_in.dir = rz[VAL_W-1:0];
            state_in   = C_DONE;
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff  <= req_in;
      mlin_ff <= mlin_in;
      mang_ff <= mang_in;
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      sqn_ff  <= sqn_in;
      sqr_ff  <= sqr_in;
      sqb_ff  <= sqb_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      z_ff    <= z_in;
      res_ff  <= res_in;
   end

   assign sts.busy = (state_ff != C_IDLE);
   assign sts.done = (state_ff == C_DONE);
   assign res      = res_ff;

endmodule

`default_nettype wire

FILE: hdl/drive_command_arbiter_watchdog_top.sv
// Drive command arbiter with per-source watchdog: top level.
// Depends on dcaw_pkg, the channel interfaces in dcaw_if.sv and dcaw_calc.
//
// Usage:
//  req_if carries one transaction per command or tick. mode selects a tick
//  (no value fields used) or a message from the joystick, movement or
//  auxiliary source. A message in a format its source takes updates its stored
//  command and produces no response; a tick produces exactly one rsp_if
//  transaction with the command of the source holding priority (joystick hold,
//  then auxiliary hold, then movement) and the three saturating timeout counters.
//  csr_if writes configuration registers 0..4 at any time; csr_if.ready is
//  always high. Write them only while no transaction is in flight.
// Timing:
//  req_if.ready is high only while the block is idle. A tick waits until the
//  output register is free. A percent-polar message is only clamped; a
//  speed-polar message runs two 38-step divisions, a speed-cartesian message
//  three divisions, a 16-step square root when both speeds are in range, up
//  to 40 normalize shifts and 23 CORDIC rotations in the one calculation unit.
// Reset and stall:
//  reset clears all stored commands, ages, holds and counters and restores
//  the register defaults. While rsp_if stalls, a response holds in the output
//  register; one more tick is taken but waits until that register frees up.
`default_nettype none

module drive_command_arbiter_watchdog_top import dcaw_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   dcaw_req_if.sink    req_if,
   dcaw_rsp_if.source  rsp_if,
   dcaw_csr_if.sink    csr_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_TICK = 2'd2;

   typedef struct packed {
      logic signed [VAL_W-1:0] direction_out;
      logic signed [PCT_W-1:0] linear_out;
      logic signed [PCT_W-1:0] angular_out;
      logic [GAIN_W-1:0]       gain_out;
      logic [SRC_W-1:0]        selected_source;
      logic [CNT_W-1:0]        movement_timeouts;
      logic [CNT_W-1:0]        joystick_timeouts;
      logic [CNT_W-1:0]        auxiliary_timeouts;
   } rsp_pay_type;

   // configuration
   logic [VMAX_W-1:0] max_lin_ff, max_lin_in, max_ang_ff, max_ang_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in, hold_ff, hold_in;
   logic [GAIN_W-1:0] joy_thr_ff, joy_thr_in;

   // per-source state
   src_vals_type      vals_ff [NUM_SRC];
   src_vals_type      vals_in [NUM_SRC];
   logic [TICK_W-1:0] ages_ff [NUM_SRC];
   logic [TICK_W-1:0] ages_in [NUM_SRC];
   logic [CNT_W-1:0]  tocnt_ff [NUM_SRC];
   logic [CNT_W-1:0]  tocnt_in [NUM_SRC];
   logic [TICK_W-1:0] joy_hold_ff, joy_hold_in, aux_hold_ff, aux_hold_in;

   logic [1:0]        state_ff, state_in;
   logic [SRC_W-1:0]  msg_src_ff, msg_src_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_pay_type       rsp_pay_ff, rsp_pay_in;

   logic              req_accept;
   logic [SRC_W-1:0]  req_src;
   logic              req_drop;
   logic              out_free;
   logic [SRC_W-1:0]  sel;
   calc_ctl_type      calc_ctl;
   calc_req_type      calc_req;
   calc_sts_type      calc_sts;
   src_vals_type      calc_res;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      case (req_if.mode)
         MODE_JOY: req_src = SRC_JOY;
         MODE_AUX: req_src = SRC_AUX;
         default:  req_src = SRC_MOV;
      endcase
   end

   // drop unused formats; joystick takes only percent polar
   assign req_drop = (req_if.format == FMT_NONE) ||
                     (req_src == SRC_JOY && req_if.format != FMT_PCT_POLAR);

   assign calc_ctl.start   = req_accept && req_if.mode != MODE_TICK && !req_drop;
   assign calc_ctl.max_lin = max_lin_ff;
   assign calc_ctl.max_ang = max_ang_ff;
   assign calc_req.fmt     = req_if.format;
   assign calc_req.a       = req_if.value_a;
   assign calc_req.b       = req_if.value_b;
   assign calc_req.c       = req_if.value_c;
   assign calc_req.d       = req_if.value_d;

   dcaw_calc u_calc (
      .clock (clock),
      .reset (reset),
      .ctl   (calc_ctl),
      .req   (calc_req),
      .sts   (calc_sts),
      .res   (calc_res)
   );

   // priority: joystick hold, then auxiliary hold, then movement
   assign sel = (joy_hold_ff != '0) ? SRC_JOY : ((aux_hold_ff != '0) ? SRC_AUX : SRC_MOV);

   always_comb begin
      max_lin_in   = max_lin_ff;
      max_ang_in   = max_ang_ff;
      timeout_in   = timeout_ff;
      hold_in      = hold_ff;
      joy_thr_in   = joy_thr_ff;
      vals_in      = vals_ff;
      ages_in      = ages_ff;
      tocnt_in     = tocnt_ff;
      joy_hold_in  = joy_hold_ff;
      aux_hold_in  = aux_hold_ff;
      state_in     = state_ff;
      msg_src_in   = msg_src_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pay_in   = rsp_pay_ff;

      // retire a taken response
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      if (csr_if.valid) begin
         case (csr_if.index)
            REG_MAX_LIN: max_lin_in = csr_if.data;
            REG_MAX_ANG: max_ang_in = csr_if.data;
            REG_TIMEOUT: timeout_in = csr_if.data[TICK_W-1:0];
            REG_HOLD:    hold_in    = csr_if.data[TICK_W-1:0];
            REG_JOY_THR: joy_thr_in = csr_if.data[GAIN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.mode == MODE_TICK) begin
                  state_in = ST_TICK;
               end else if (!req_drop) begin
                  msg_src_in = req_src;
                  state_in   = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (calc_sts.done) begin
               // store the new command, restart its age, arm holds
               vals_in[msg_src_ff] = calc_res;
               ages_in[msg_src_ff] = '0;
               if (msg_src_ff == SRC_JOY && calc_res.gain > joy_thr_ff) joy_hold_in = hold_ff;
               if (msg_src_ff == SRC_AUX) aux_hold_in = hold_ff;
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_pay_in.direction_out      = vals_ff[sel].dir;
               rsp_pay_in.linear_out         = vals_ff[sel].lin;
               rsp_pay_in.angular_out        = vals_ff[sel].ang;
               rsp_pay_in.gain_out           = vals_ff[sel].gain;
               rsp_pay_in.selected_source    = sel;
               rsp_pay_in.movement_timeouts  = tocnt_ff[SRC_MOV];
               rsp_pay_in.joystick_timeouts  = tocnt_ff[SRC_JOY];
               rsp_pay_in.auxiliary_timeouts = tocnt_ff[SRC_AUX];
               // watchdog: zero stale sources and count, else age them
               for (int i = 0; i < NUM_SRC; i++) begin
                  if (ages_ff[i] >= timeout_ff) begin
                     vals_in[i] = '0;
                     if (tocnt_ff[i] != '1) tocnt_in[i] = tocnt_ff[i] + CNT_W'(1);
                  end else if (ages_ff[i] != '1) begin
                     ages_in[i] = ages_ff[i] + TICK_W'(1);
                  end
               end
               if (joy_hold_ff != '0) joy_hold_in = joy_hold_ff - TICK_W'(1);
               if (aux_hold_ff != '0) aux_hold_in = aux_hold_ff - TICK_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lin_ff   <= VMAX_W'(256);
         max_ang_ff   <= VMAX_W'(7680);
         timeout_ff   <= TICK_W'(10);
         hold_ff      <= TICK_W'(100);
         joy_thr_ff   <= GAIN_W'(2560);
         for (int i = 0; i < NUM_SRC; i++) begin
            vals_ff[i]  <= '0;
            ages_ff[i]  <= '0;
            tocnt_ff[i] <= '0;
         end
         joy_hold_ff  <= '0;
         aux_hold_ff  <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_lin_ff   <= max_lin_in;
         max_ang_ff   <= max_ang_in;
         timeout_ff   <= timeout_in;
         hold_ff      <= hold_in;
         joy_thr_ff   <= joy_thr_in;
         vals_ff      <= vals_in;
         ages_ff      <= ages_in;
         tocnt_ff     <= tocnt_in;
         joy_hold_ff  <= joy_hold_in;
         aux_hold_ff  <= aux_hold_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      msg_src_ff <= msg_src_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.direction_out      = rsp_pay_ff.direction_out;
   assign rsp_if.linear_out         = rsp_pay_ff.linear_out;
   assign rsp_if.angular_out        = rsp_pay_ff.angular_out;
   assign rsp_if.gain_out           = rsp_pay_ff.gain_out;
   assign rsp_if.selected_source    = rsp_pay_ff.selected_source;
   assign rsp_if.movement_timeouts  = rsp_pay_ff.movement_timeouts;
   assign rsp_if.joystick_timeouts  = rsp_pay_ff.joystick_timeouts;
   assign rsp_if.auxiliary_timeouts = rsp_pay_ff.auxiliary_timeouts;

   // the calculation unit finishes only for a message in flight
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      calc_sts.done |-> (state_ff == ST_CALC))
      else $error("calc done outside message state");

   // an accepted tick goes straight to the tick state
   a_tick_entry: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.mode == MODE_TICK) |=> (state_ff == ST_TICK))
      else $error("tick not entered");

   // a tick with a free output register produces a response
   a_tick_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("tick lost");

   // a new response is only produced by a tick
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == ST_TICK))
      else $error("spurious response");

   a_sel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pay_ff.selected_source == SRC_MOV ||
                        rsp_pay_ff.selected_source == SRC_AUX ||
                        rsp_pay_ff.selected_source == SRC_JOY))
      else $error("bad selected source");

endmodule

`default_nettype wire
